/* hw/rtl/lbc_pkg.sv */
// lbc_pkg: shared types, codes and constants of the byte budget lru cache
// no dependencies; imported by every module of the block

package lbc_pkg;

   // configuration and payload widths
   localparam int unsigned DEF_ENTRIES  = 16;
   localparam int unsigned ID_W         = 64;
   localparam int unsigned TYPE_W       = 32;
   localparam int unsigned BYTES_W      = 32;
   localparam int unsigned TOTAL_W      = 38;
   localparam int unsigned COUNT_OUT_W  = 6;
   localparam int unsigned MODE_W       = 3;
   localparam int unsigned STATUS_W     = 2;
   localparam int unsigned CSR_ADDR_W   = 3;
   localparam int unsigned CSR_DATA_W   = 64;

   // request modes
   localparam logic [MODE_W-1:0] MODE_UPLOAD   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_EVICT    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_LOOKUP   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_CONTAINS = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd4;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISS    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

   // result kinds
   localparam logic KIND_FINAL  = 1'b0;
   localparam logic KIND_NOTICE = 1'b1;

   // register addresses
   localparam logic [CSR_ADDR_W-1:0] ADDR_BYTE_BUDGET = 3'd0;

   // one table entry as held in the memory
   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [TYPE_W-1:0]  typ;
      logic [BYTES_W-1:0] bytes;
   } slot_rec_type;

   // controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_RESOLVE,
      S_EVCHK,
      S_EVRD,
      S_INSERT,
      S_REPLY
   } state_type;

endpackage

/* hw/rtl/lbc_store.sv */
// lbc_store: table memory with one write port and one registered read port, holding id, type and size of each slot
// depends on lbc_pkg for the entry record type

module lbc_store #(
   parameter int unsigned ENTRIES = lbc_pkg::DEF_ENTRIES
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(ENTRIES)-1:0]   wr_addr,
   input  lbc_pkg::slot_rec_type        wr_data,
   input  logic                         rd_en,
   input  logic [$clog2(ENTRIES)-1:0]   rd_addr,
   output lbc_pkg::slot_rec_type        rd_data
);
   import lbc_pkg::*;

   slot_rec_type mem [ENTRIES];
   slot_rec_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/lbc_csr.sv */
// lbc_csr: apb style register port holding the byte budget
// depends on lbc_pkg for widths and register addresses

module lbc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [lbc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [lbc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [lbc_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   output logic [lbc_pkg::TOTAL_W-1:0]     byte_budget
);
   import lbc_pkg::*;

   logic [TOTAL_W-1:0] budget_ff;
   logic [TOTAL_W-1:0] budget_in;
   logic               wr_hit;

   // write decode
   assign wr_hit = csr_psel && csr_penable && csr_pwrite && (csr_paddr == ADDR_BYTE_BUDGET);

   always_comb begin
      budget_in = budget_ff;
      if (wr_hit) begin
         budget_in = csr_pwdata[TOTAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= '0;
      end else begin
         budget_ff <= budget_in;
      end
   end

   // read back
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == ADDR_BYTE_BUDGET) begin
         csr_prdata = {{(CSR_DATA_W-TOTAL_W){1'b0}}, budget_ff};
      end
   end

   assign csr_pready  = 1'b1;
   assign byte_budget = budget_ff;

endmodule

/* hw/rtl/byte_budget_lru_cache.sv */
// byte_budget_lru_cache: top level with the sequencing controller and recency lanes
// depends on lbc_pkg, lbc_store and lbc_csr
//
// Usage
//   req_* carries one item (mode, id, type, size) under valid/ready; rsp_* returns
//   the result items, eviction notices first, then one final answer with last set.
//   csr_* is an apb style port with the byte budget at address 0 (0 = unlimited).
// Timing
//   one item is worked on at a time. id search reads the table memory one slot
//   per cycle and ends early on a match; each eviction of an upload adds the
//   oldest slot check, the read and drop, and the notice. clear and rejected
//   items go straight to the reply. the memory read port is the limit.
// Reset
//   synchronous, active high: table empty, totals zero, budget zero, no result.
// Stalls
//   results sit in an output register; while rsp_ready is low the controller
//   holds before its next result and accepts no item until the final one is out.

module byte_budget_lru_cache #(
   parameter int unsigned ENTRIES = lbc_pkg::DEF_ENTRIES
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [lbc_pkg::MODE_W-1:0]        req_mode,
   input  logic [lbc_pkg::ID_W-1:0]          req_item_id,
   input  logic [lbc_pkg::TYPE_W-1:0]        req_item_type,
   input  logic [lbc_pkg::BYTES_W-1:0]       req_item_bytes,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_result_kind,
   output logic [lbc_pkg::STATUS_W-1:0]      rsp_status,
   output logic [lbc_pkg::ID_W-1:0]          rsp_victim_id,
   output logic [lbc_pkg::TYPE_W-1:0]        rsp_found_type,
   output logic [lbc_pkg::BYTES_W-1:0]       rsp_found_bytes,
   output logic [lbc_pkg::COUNT_OUT_W-1:0]   rsp_entry_count,
   output logic [lbc_pkg::TOTAL_W-1:0]       rsp_bytes_held,
   output logic                              rsp_last,
   // configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lbc_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [lbc_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [lbc_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import lbc_pkg::*;

   localparam int unsigned IW = $clog2(ENTRIES);
   localparam int unsigned RW = $clog2(ENTRIES);
   localparam int unsigned CW = $clog2(ENTRIES + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

   // controller state
   state_type            state_ff, state_in;
   logic [MODE_W-1:0]    mode_ff, mode_in;
   logic [ID_W-1:0]      id_ff, id_in;
   logic [TYPE_W-1:0]    type_ff, type_in;
   logic [BYTES_W-1:0]   bytes_ff, bytes_in;
   logic [IW-1:0]        scan_ff, scan_in;
   logic [IW-1:0]        cmp_idx_ff, cmp_idx_in;
   logic                 cmp_vld_ff, cmp_vld_in;
   logic                 hit_ff, hit_in;
   logic [IW-1:0]        hit_idx_ff, hit_idx_in;
   logic [TYPE_W-1:0]    hit_type_ff, hit_type_in;
   logic [BYTES_W-1:0]   hit_bytes_ff, hit_bytes_in;
   logic [IW-1:0]        vic_idx_ff, vic_idx_in;

   // pending result
   logic                 rep_kind_ff, rep_kind_in;
   logic [STATUS_W-1:0]  rep_status_ff, rep_status_in;
   logic [ID_W-1:0]      rep_victim_ff, rep_victim_in;
   logic [TYPE_W-1:0]    rep_type_ff, rep_type_in;
   logic [BYTES_W-1:0]   rep_bytes_ff, rep_bytes_in;
   logic                 rep_last_ff, rep_last_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_kind_ff, rsp_kind_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]      rsp_victim_ff, rsp_victim_in;
   logic [TYPE_W-1:0]    rsp_type_ff, rsp_type_in;
   logic [BYTES_W-1:0]   rsp_bytes_ff, rsp_bytes_in;
   logic [CW-1:0]        rsp_count_ff, rsp_count_in;
   logic [TOTAL_W-1:0]   rsp_total_ff, rsp_total_in;
   logic                 rsp_last_ff, rsp_last_in;

   // table lanes and totals
   logic                 valid_ff [ENTRIES];
   logic                 valid_in [ENTRIES];
   logic [RW-1:0]        rank_ff  [ENTRIES];
   logic [RW-1:0]        rank_in  [ENTRIES];
   logic [CW-1:0]        count_ff, count_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;

   // lane controls
   logic                 drop_en, newest_en, insert_en, clear_en;
   logic [IW-1:0]        sel_idx;
   logic [BYTES_W-1:0]   drop_bytes;
   logic [RW-1:0]        sel_rank;

   // memory side
   logic                 mem_wr_en, mem_rd_en;
   logic [IW-1:0]        mem_rd_addr;
   slot_rec_type         mem_wr_data, mem_rd_data;

   // derived
   logic [TOTAL_W-1:0]   budget;
   logic [IW-1:0]        free_idx, oldest_idx;
   logic                 out_free;
   logic                 id_match;
   logic                 evict_need;
   logic [TOTAL_W:0]     sum_wide;

   lbc_store #(.ENTRIES(ENTRIES)) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (free_idx),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   lbc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .byte_budget (budget)
   );

   // first free slot and least recent slot
   always_comb begin
      free_idx   = '0;
      oldest_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IW'(i);
         end
      end
      for (int i = 0; i < ENTRIES; i++) begin
         if (valid_ff[i] && (rank_ff[i] == RW'(count_ff - 1'b1))) begin
            oldest_idx = IW'(i);
         end
      end
   end

   // eviction test for an upload
   assign sum_wide   = {1'b0, total_ff} + {{(TOTAL_W + 1 - BYTES_W){1'b0}}, bytes_ff};
   assign evict_need = ((budget != '0) && (count_ff != '0) &&
                        (sum_wide > {1'b0, budget})) || (count_ff == FULL_CNT);

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign id_match = cmp_vld_ff && valid_ff[cmp_idx_ff] && (mem_rd_data.id == id_ff);
   assign sel_rank = rank_ff[sel_idx];

   assign mem_wr_data.id    = id_ff;
   assign mem_wr_data.typ   = type_ff;
   assign mem_wr_data.bytes = bytes_ff;

   // controller: next state and outputs
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      id_in         = id_ff;
      type_in       = type_ff;
      bytes_in      = bytes_ff;
      scan_in       = scan_ff;
      cmp_idx_in    = cmp_idx_ff;
      cmp_vld_in    = 1'b0;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_type_in   = hit_type_ff;
      hit_bytes_in  = hit_bytes_ff;
      vic_idx_in    = vic_idx_ff;
      rep_kind_in   = rep_kind_ff;
      rep_status_in = rep_status_ff;
      rep_victim_in = rep_victim_ff;
      rep_type_in   = rep_type_ff;
      rep_bytes_in  = rep_bytes_ff;
      rep_last_in   = rep_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_status_in = rsp_status_ff;
      rsp_victim_in = rsp_victim_ff;
      rsp_type_in   = rsp_type_ff;
      rsp_bytes_in  = rsp_bytes_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_last_in   = rsp_last_ff;
      drop_en       = 1'b0;
      newest_en     = 1'b0;
      insert_en     = 1'b0;
      clear_en      = 1'b0;
      sel_idx       = hit_idx_ff;
      drop_bytes    = hit_bytes_ff;
      mem_wr_en     = 1'b0;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = scan_ff;
      req_ready     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready     = 1'b1;
            rep_kind_in   = KIND_FINAL;
            rep_status_in = STATUS_OK;
            rep_victim_in = '0;
            rep_type_in   = '0;
            rep_bytes_in  = '0;
            rep_last_in   = 1'b1;
            if (req_valid) begin
               mode_in  = req_mode;
               id_in    = req_item_id;
               type_in  = req_item_type;
               bytes_in = req_item_bytes;
               scan_in  = '0;
               hit_in   = 1'b0;
               if ((req_mode > MODE_CLEAR) ||
                   ((req_mode == MODE_UPLOAD) && (req_item_bytes == '0))) begin
                  rep_status_in = STATUS_INVALID;
                  state_in      = S_REPLY;
               end else if (req_mode == MODE_CLEAR) begin
                  clear_en = 1'b1;
                  state_in = S_REPLY;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end

         // one slot read per cycle, compared against the id in the next cycle
         S_SCAN: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = scan_ff;
            cmp_vld_in  = 1'b1;
            cmp_idx_in  = scan_ff;
            if (scan_ff != LAST_IDX) begin
               scan_in = scan_ff + 1'b1;
            end
            if (id_match) begin
               hit_in       = 1'b1;
               hit_idx_in   = cmp_idx_ff;
               hit_type_in  = mem_rd_data.typ;
               hit_bytes_in = mem_rd_data.bytes;
               state_in     = S_RESOLVE;
            end else if (cmp_vld_ff && (cmp_idx_ff == LAST_IDX)) begin
               state_in = S_RESOLVE;
            end
         end

         S_RESOLVE: begin
            sel_idx    = hit_idx_ff;
            drop_bytes = hit_bytes_ff;
            priority case (1'b1)
               (mode_ff == MODE_UPLOAD): begin
                  drop_en  = hit_ff;
                  state_in = S_EVCHK;
               end
               !hit_ff: begin
                  rep_status_in = STATUS_MISS;
                  state_in      = S_REPLY;
               end
               (mode_ff == MODE_EVICT): begin
                  drop_en      = 1'b1;
                  rep_bytes_in = hit_bytes_ff;
                  state_in     = S_REPLY;
               end
               (mode_ff == MODE_LOOKUP): begin
                  newest_en    = 1'b1;
                  rep_type_in  = hit_type_ff;
                  rep_bytes_in = hit_bytes_ff;
                  state_in     = S_REPLY;
               end
               default: begin
                  state_in = S_REPLY;
               end
            endcase
         end

         // evict least recent while over budget or full
         S_EVCHK: begin
            if (evict_need) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = oldest_idx;
               vic_idx_in  = oldest_idx;
               state_in    = S_EVRD;
            end else begin
               state_in = S_INSERT;
            end
         end

         S_EVRD: begin
            sel_idx       = vic_idx_ff;
            drop_bytes    = mem_rd_data.bytes;
            drop_en       = 1'b1;
            rep_kind_in   = KIND_NOTICE;
            rep_status_in = STATUS_OK;
            rep_victim_in = mem_rd_data.id;
            rep_type_in   = '0;
            rep_bytes_in  = mem_rd_data.bytes;
            rep_last_in   = 1'b0;
            state_in      = S_REPLY;
         end

         S_INSERT: begin
            mem_wr_en     = 1'b1;
            insert_en     = 1'b1;
            rep_kind_in   = KIND_FINAL;
            rep_status_in = STATUS_OK;
            rep_victim_in = '0;
            rep_type_in   = '0;
            rep_bytes_in  = '0;
            rep_last_in   = 1'b1;
            state_in      = S_REPLY;
         end

         // hand the pending result to the output register
         S_REPLY: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = rep_kind_ff;
               rsp_status_in = rep_status_ff;
               rsp_victim_in = rep_victim_ff;
               rsp_type_in   = rep_type_ff;
               rsp_bytes_in  = rep_bytes_ff;
               rsp_count_in  = count_ff;
               rsp_total_in  = total_ff;
               rsp_last_in   = rep_last_ff;
               state_in      = rep_last_ff ? S_IDLE : S_EVCHK;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // recency lanes, valid bits and totals
   always_comb begin
      count_in = count_ff;
      total_in = total_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         valid_in[i] = valid_ff[i];
         rank_in[i]  = rank_ff[i];
         if (clear_en) begin
            valid_in[i] = 1'b0;
         end else if (drop_en) begin
            if (valid_ff[i] && (rank_ff[i] > sel_rank)) begin
               rank_in[i] = rank_ff[i] - 1'b1;
            end
            if (IW'(i) == sel_idx) begin
               valid_in[i] = 1'b0;
            end
         end else if (newest_en) begin
            if (IW'(i) == sel_idx) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && (rank_ff[i] < sel_rank)) begin
               rank_in[i] = rank_ff[i] + 1'b1;
            end
         end else if (insert_en) begin
            if (IW'(i) == free_idx) begin
               valid_in[i] = 1'b1;
               rank_in[i]  = '0;
            end else if (valid_ff[i]) begin
               rank_in[i] = rank_ff[i] + 1'b1;
            end
         end
      end
      if (clear_en) begin
         count_in = '0;
         total_in = '0;
      end else if (drop_en) begin
         total_in = total_ff - {{(TOTAL_W - BYTES_W){1'b0}}, drop_bytes};
         if (count_ff != '0) begin
            count_in = count_ff - 1'b1;
         end
      end else if (insert_en) begin
         count_in = count_ff + 1'b1;
         total_in = total_ff + {{(TOTAL_W - BYTES_W){1'b0}}, bytes_ff};
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         count_ff     <= '0;
         total_ff     <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cmp_vld_ff   <= cmp_vld_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         for (int i = 0; i < ENTRIES; i++) begin
            valid_ff[i] <= valid_in[i];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      id_ff         <= id_in;
      type_ff       <= type_in;
      bytes_ff      <= bytes_in;
      scan_ff       <= scan_in;
      cmp_idx_ff    <= cmp_idx_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      hit_type_ff   <= hit_type_in;
      hit_bytes_ff  <= hit_bytes_in;
      vic_idx_ff    <= vic_idx_in;
      rep_kind_ff   <= rep_kind_in;
      rep_status_ff <= rep_status_in;
      rep_victim_ff <= rep_victim_in;
      rep_type_ff   <= rep_type_in;
      rep_bytes_ff  <= rep_bytes_in;
      rep_last_ff   <= rep_last_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_victim_ff <= rsp_victim_in;
      rsp_type_ff   <= rsp_type_in;
      rsp_bytes_ff  <= rsp_bytes_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_last_ff   <= rsp_last_in;
      for (int i = 0; i < ENTRIES; i++) begin
         rank_ff[i] <= rank_in[i];
      end
   end

   // result ports
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_victim_id   = rsp_victim_ff;
   assign rsp_found_type  = rsp_type_ff;
   assign rsp_found_bytes = rsp_bytes_ff;
   assign rsp_entry_count = {{(COUNT_OUT_W - CW){1'b0}}, rsp_count_ff};
   assign rsp_bytes_held  = rsp_total_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

/* hw/rtl/lbc_checker.sv */
// lbc_checker: port level assertions for the byte budget lru cache, with bind
// depends on lbc_pkg; attaches to byte_budget_lru_cache

module lbc_checker #(
   parameter int unsigned ENTRIES = lbc_pkg::DEF_ENTRIES
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              rsp_result_kind,
   input logic [lbc_pkg::STATUS_W-1:0]      rsp_status,
   input logic [lbc_pkg::COUNT_OUT_W-1:0]   rsp_entry_count,
   input logic [lbc_pkg::TOTAL_W-1:0]       rsp_bytes_held,
   input logic                              rsp_last
);
   import lbc_pkg::*;

   // a stalled item stays valid and holds its byte total and last flag
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bytes_held) && $stable(rsp_last))
      else $error("stalled result changed");

   // notices are never the final result
   a_notice_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == KIND_NOTICE) |-> !rsp_last)
      else $error("notice marked last");

   // notices always report ok
   a_notice_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == KIND_NOTICE) |-> (rsp_status == STATUS_OK))
      else $error("notice with error status");

   // occupancy never exceeds the table
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_count <= COUNT_OUT_W'(ENTRIES)))
      else $error("entry count above table size");

   // an empty table holds no bytes
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_entry_count == '0) |-> (rsp_bytes_held == '0))
      else $error("bytes held with empty table");

endmodule

bind byte_budget_lru_cache lbc_checker #(.ENTRIES(ENTRIES)) u_lbc_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_result_kind (rsp_result_kind),
   .rsp_status      (rsp_status),
   .rsp_entry_count (rsp_entry_count),
   .rsp_bytes_held  (rsp_bytes_held),
   .rsp_last        (rsp_last)
);
